@@ src/m4ci_pkg.sv @@
// Shared constants and types for the 4x4 cofactor matrix inverse unit.
`timescale 1ns / 1ps

package m4ci_pkg;

  localparam int ELEM_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MDET_W     = 63;
  localparam int MDET_FRAC  = 32;
  localparam int N_ELEM     = 16;
  localparam int ADDR_W     = $clog2(N_ELEM);
  localparam int DIG_W      = 8;
  localparam int N_DIG      = ELEM_W / DIG_W;
  localparam int DIG_IDX_W  = $clog2(N_DIG);
  localparam int T_W        = 2 * ELEM_W + 1;
  localparam int COF_W      = 3 * ELEM_W + 3;
  localparam int ACC_W      = 4 * ELEM_W + 6;
  localparam int PP_W       = COF_W + DIG_W + 1;
  localparam int Q_W        = ELEM_W + 2;
  localparam int DIV_W      = ACC_W + ELEM_W + 2;
  localparam int DCNT_W     = $clog2(Q_W + 1);
  localparam int CMP_W      = ACC_W + MDET_W + 4 * FRAC_BITS + MDET_FRAC;
  localparam int PH_MAC0    = 3;
  localparam int PH_LAST    = PH_MAC0 + N_DIG;
  localparam int PH_W       = $clog2(PH_LAST + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MINOR,
    ST_DET,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    WS_MEM,
    WS_T0,
    WS_T1,
    WS_T2,
    WS_COF
  } wsrc_t;

  typedef enum logic [2:0] {
    SD_NONE,
    SD_T0,
    SD_T1,
    SD_T2,
    SD_COF,
    SD_DET
  } store_t;

  typedef struct packed {
    logic                 mem_wr;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 acc_clr;
    logic                 ld_w;
    wsrc_t                wsrc;
    logic                 ld_x;
    logic                 mac;
    logic [DIG_IDX_W-1:0] dig;
    logic                 sub;
    store_t               st;
    logic [ADDR_W-1:0]    cof_idx;
    logic                 cof_neg;
    logic                 chk;
    logic                 div_init;
    logic                 div_step;
    logic                 out_load;
    logic                 last;
  } cmd_t;

  typedef struct packed {
    logic sing;
    logic out_free;
  } stat_t;

endpackage

@@ src/m4ci_ctrl.sv @@
// Sequencer for load, minors, determinant, division and result hand-off.
`timescale 1ns / 1ps

module m4ci_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  m4ci_pkg::stat_t   stat,
  output m4ci_pkg::cmd_t    cmd
);

  localparam logic [3:0] PROD_LAST = 4'd8;
  localparam logic [3:0] DET_LAST  = 4'd3;
  localparam logic [m4ci_pkg::ADDR_W-1:0] IDX_LAST = {m4ci_pkg::ADDR_W{1'b1}};
  localparam logic [m4ci_pkg::PH_W-1:0] PH_END =
    m4ci_pkg::PH_W'(m4ci_pkg::PH_LAST);
  localparam logic [m4ci_pkg::PH_W-1:0] PH_M0 =
    m4ci_pkg::PH_W'(m4ci_pkg::PH_MAC0);
  localparam logic [m4ci_pkg::PH_W-1:0] PH_M_END =
    m4ci_pkg::PH_W'(m4ci_pkg::PH_MAC0 + m4ci_pkg::N_DIG);
  localparam logic [m4ci_pkg::DCNT_W-1:0] DCNT_END =
    m4ci_pkg::DCNT_W'(m4ci_pkg::Q_W);

  m4ci_pkg::state_t                state_r, state_nxt;
  logic [m4ci_pkg::ADDR_W-1:0]     ld_cnt_r, ld_cnt_nxt;
  logic [m4ci_pkg::ADDR_W-1:0]     idx_r, idx_nxt;
  logic [3:0]                      prod_r, prod_nxt;
  logic [m4ci_pkg::PH_W-1:0]       ph_r, ph_nxt;
  logic [m4ci_pkg::DCNT_W-1:0]     dcnt_r, dcnt_nxt;
  logic                            accept;

  function automatic logic [1:0] skip(input logic [1:0] i, input logic [1:0] s);
    return (i >= s) ? i + 2'd1 : i;
  endfunction

  assign accept   = in_valid && (state_r == m4ci_pkg::ST_LOAD);
  assign in_stall = (state_r != m4ci_pkg::ST_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= m4ci_pkg::ST_LOAD;
      ld_cnt_r <= '0;
      idx_r    <= '0;
      prod_r   <= '0;
      ph_r     <= '0;
      dcnt_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ld_cnt_r <= ld_cnt_nxt;
      idx_r    <= idx_nxt;
      prod_r   <= prod_nxt;
      ph_r     <= ph_nxt;
      dcnt_r   <= dcnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ld_cnt_nxt = ld_cnt_r;
    idx_nxt    = idx_r;
    prod_nxt   = prod_r;
    ph_nxt     = ph_r;
    dcnt_nxt   = dcnt_r;
    unique case (state_r)
      m4ci_pkg::ST_LOAD: begin
        if (accept) begin
          ld_cnt_nxt = ld_cnt_r + 1'b1;
          if (ld_cnt_r == IDX_LAST) begin
            state_nxt = m4ci_pkg::ST_MINOR;
            idx_nxt   = '0;
            prod_nxt  = '0;
            ph_nxt    = '0;
          end
        end
      end
      m4ci_pkg::ST_MINOR: begin
        ph_nxt = ph_r + 1'b1;
        if (ph_r == PH_END) begin
          ph_nxt = '0;
          if (prod_r == PROD_LAST) begin
            prod_nxt = '0;
            idx_nxt  = idx_r + 1'b1;
            if (idx_r == IDX_LAST) begin
              state_nxt = m4ci_pkg::ST_DET;
            end
          end else begin
            prod_nxt = prod_r + 1'b1;
          end
        end
      end
      m4ci_pkg::ST_DET: begin
        ph_nxt = ph_r + 1'b1;
        if (ph_r == PH_END) begin
          ph_nxt = '0;
          if (prod_r == DET_LAST) begin
            prod_nxt  = '0;
            state_nxt = m4ci_pkg::ST_CHECK;
          end else begin
            prod_nxt = prod_r + 1'b1;
          end
        end
      end
      m4ci_pkg::ST_CHECK: begin
        state_nxt = m4ci_pkg::ST_DIV;
        dcnt_nxt  = '0;
        idx_nxt   = '0;
      end
      m4ci_pkg::ST_DIV: begin
        if (((dcnt_r == '0) && stat.sing) || (dcnt_r == DCNT_END)) begin
          state_nxt = m4ci_pkg::ST_EMIT;
        end else begin
          dcnt_nxt = dcnt_r + 1'b1;
        end
      end
      m4ci_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          idx_nxt  = idx_r + 1'b1;
          dcnt_nxt = '0;
          state_nxt = (idx_r == IDX_LAST) ? m4ci_pkg::ST_LOAD : m4ci_pkg::ST_DIV;
        end
      end
      default: state_nxt = m4ci_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    logic [1:0]       wi, wj, xi, xj;
    m4ci_pkg::wsrc_t  ws;
    logic             sub, clr;
    m4ci_pkg::store_t st;
    logic [1:0]       sr, sc;
    logic             mac_ph;

    wi = 2'd0; wj = 2'd0; xi = 2'd0; xj = 2'd0;
    ws = m4ci_pkg::WS_MEM;
    sub = 1'b0; clr = 1'b0;
    st = m4ci_pkg::SD_NONE;
    sr = idx_r[3:2];
    sc = idx_r[1:0];
    mac_ph = (ph_r >= PH_M0) && (ph_r < PH_M_END);
    cmd = '0;

    case (prod_r)
      4'd0: begin wi = 2'd1; wj = 2'd1; xi = 2'd2; xj = 2'd2; clr = 1'b1; end
      4'd1: begin
        wi = 2'd1; wj = 2'd2; xi = 2'd2; xj = 2'd1; sub = 1'b1; st = m4ci_pkg::SD_T0;
      end
      4'd2: begin wi = 2'd0; wj = 2'd1; xi = 2'd2; xj = 2'd2; clr = 1'b1; end
      4'd3: begin
        wi = 2'd0; wj = 2'd2; xi = 2'd2; xj = 2'd1; sub = 1'b1; st = m4ci_pkg::SD_T1;
      end
      4'd4: begin wi = 2'd0; wj = 2'd1; xi = 2'd1; xj = 2'd2; clr = 1'b1; end
      4'd5: begin
        wi = 2'd0; wj = 2'd2; xi = 2'd1; xj = 2'd1; sub = 1'b1; st = m4ci_pkg::SD_T2;
      end
      4'd6: begin ws = m4ci_pkg::WS_T0; xi = 2'd0; xj = 2'd0; clr = 1'b1; end
      4'd7: begin ws = m4ci_pkg::WS_T1; xi = 2'd1; xj = 2'd0; sub = 1'b1; end
      4'd8: begin ws = m4ci_pkg::WS_T2; xi = 2'd2; xj = 2'd0; st = m4ci_pkg::SD_COF; end
      default: begin end
    endcase

    unique case (state_r)
      m4ci_pkg::ST_LOAD: begin
        cmd.mem_wr  = accept;
        cmd.wr_addr = ld_cnt_r;
      end
      m4ci_pkg::ST_MINOR: begin
        cmd.rd_addr = (ph_r == '0) ? {skip(wi, sr), skip(wj, sc)}
                                   : {skip(xi, sr), skip(xj, sc)};
        cmd.acc_clr = (ph_r == '0) && clr;
        cmd.ld_w    = (ph_r == m4ci_pkg::PH_W'(1));
        cmd.wsrc    = ws;
        cmd.ld_x    = (ph_r == m4ci_pkg::PH_W'(2));
        cmd.mac     = mac_ph;
        cmd.dig     = m4ci_pkg::DIG_IDX_W'(ph_r - PH_M0);
        cmd.sub     = sub;
        cmd.st      = (ph_r == PH_END) ? st : m4ci_pkg::SD_NONE;
        cmd.cof_idx = idx_r;
        cmd.cof_neg = idx_r[2] ^ idx_r[0];
      end
      m4ci_pkg::ST_DET: begin
        cmd.rd_addr = {prod_r[1:0], 2'b00};
        cmd.acc_clr = (ph_r == '0) && (prod_r == '0);
        cmd.ld_w    = (ph_r == m4ci_pkg::PH_W'(1));
        cmd.wsrc    = m4ci_pkg::WS_COF;
        cmd.ld_x    = (ph_r == m4ci_pkg::PH_W'(2));
        cmd.mac     = mac_ph;
        cmd.dig     = m4ci_pkg::DIG_IDX_W'(ph_r - PH_M0);
        cmd.st      = ((ph_r == PH_END) && (prod_r == DET_LAST)) ? m4ci_pkg::SD_DET
                                                                 : m4ci_pkg::SD_NONE;
        cmd.cof_idx = {prod_r[1:0], 2'b00};
      end
      m4ci_pkg::ST_CHECK: begin
        cmd.chk = 1'b1;
      end
      m4ci_pkg::ST_DIV: begin
        cmd.cof_idx  = {idx_r[1:0], idx_r[3:2]};
        cmd.div_init = (dcnt_r == '0);
        cmd.div_step = (dcnt_r != '0);
      end
      m4ci_pkg::ST_EMIT: begin
        cmd.out_load = stat.out_free;
        cmd.last     = (idx_r == IDX_LAST);
      end
      default: begin end
    endcase
  end

  a_prod_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == m4ci_pkg::ST_MINOR) |-> (prod_r <= PROD_LAST))
    else $error("product index out of range");

  a_last_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.last) |=> (state_r == m4ci_pkg::ST_LOAD))
    else $error("last result did not return to load");

endmodule

@@ src/m4ci_datapath.sv @@
// Matrix store, digit multiply-accumulate, threshold test, divider and output register.
`timescale 1ns / 1ps

module m4ci_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  m4ci_pkg::cmd_t                      cmd,
  output m4ci_pkg::stat_t                     stat,
  input  logic signed [m4ci_pkg::ELEM_W-1:0]  in_elem,
  input  logic                                cfg_we,
  input  logic [m4ci_pkg::MDET_W-1:0]         cfg_min_det,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [m4ci_pkg::ELEM_W-1:0]  out_elem,
  output logic                                out_sing,
  output logic                                out_last
);

  localparam int E = m4ci_pkg::ELEM_W;
  localparam logic [E:0]   HALF = {2'b01, {(E-1){1'b0}}};
  localparam logic [E-1:0] MAXV = {1'b0, {(E-1){1'b1}}};
  localparam logic [E-1:0] MINV = {1'b1, {(E-1){1'b0}}};

  logic [E-1:0]                              mat_mem [m4ci_pkg::N_ELEM];
  logic [E-1:0]                              rd_data_r;
  logic signed [m4ci_pkg::COF_W-1:0]         w_r, w_nxt;
  logic [E-1:0]                              x_mag_r;
  logic                                      x_neg_r;
  logic signed [m4ci_pkg::ACC_W-1:0]         acc_r;
  logic signed [m4ci_pkg::T_W-1:0]           t_r [3];
  logic signed [m4ci_pkg::COF_W-1:0]         cof_r [m4ci_pkg::N_ELEM];
  logic signed [m4ci_pkg::ACC_W-1:0]         det_r;
  logic [m4ci_pkg::ACC_W-1:0]                adet, adet_r;
  logic                                      sing_r, sing_nxt;
  logic                                      rneg_r;
  logic [m4ci_pkg::DIV_W-1:0]                rem_r, dsh_r;
  logic [m4ci_pkg::Q_W-1:0]                  q_r;
  logic [m4ci_pkg::MDET_W-1:0]               md_r;
  logic                                      out_valid_r, out_sing_r, out_last_r;
  logic [E-1:0]                              out_elem_r;

  logic signed [m4ci_pkg::COF_W-1:0]         cof_rd;
  logic [m4ci_pkg::COF_W-1:0]                acv;
  logic [m4ci_pkg::DIG_W-1:0]                digit;
  logic signed [m4ci_pkg::PP_W-1:0]          pp;
  logic signed [m4ci_pkg::ACC_W-1:0]         pp_ext, pp_sh;
  logic [m4ci_pkg::CMP_W-1:0]                lhs, rhs;
  logic                                      ge;
  logic [E:0]                                qv;
  logic                                      ovf;
  logic [E:0]                                qneg;
  logic [E-1:0]                              res, res_elem;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mat_mem[cmd.wr_addr] <= in_elem;
    end
    rd_data_r <= mat_mem[cmd.rd_addr];
  end

  assign cof_rd = cof_r[cmd.cof_idx];

  always_comb begin
    unique case (cmd.wsrc)
      m4ci_pkg::WS_MEM: w_nxt = m4ci_pkg::COF_W'($signed(rd_data_r));
      m4ci_pkg::WS_T0:  w_nxt = m4ci_pkg::COF_W'(t_r[0]);
      m4ci_pkg::WS_T1:  w_nxt = m4ci_pkg::COF_W'(t_r[1]);
      m4ci_pkg::WS_T2:  w_nxt = m4ci_pkg::COF_W'(t_r[2]);
      default:          w_nxt = cof_rd;
    endcase
  end

  assign digit  = x_mag_r[m4ci_pkg::DIG_W * cmd.dig +: m4ci_pkg::DIG_W];
  assign pp     = w_r * $signed({1'b0, digit});
  assign pp_ext = m4ci_pkg::ACC_W'(pp);
  assign pp_sh  = pp_ext << (m4ci_pkg::DIG_W * cmd.dig);

  always_ff @(posedge clk) begin
    if (cmd.ld_w) begin
      w_r <= w_nxt;
    end
    if (cmd.ld_x) begin
      x_neg_r <= rd_data_r[E-1];
      x_mag_r <= rd_data_r[E-1] ? (~rd_data_r + 1'b1) : rd_data_r;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.mac) begin
      acc_r <= (cmd.sub ^ x_neg_r) ? (acc_r - pp_sh) : (acc_r + pp_sh);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.st)
      m4ci_pkg::SD_T0:  t_r[0] <= m4ci_pkg::T_W'(acc_r);
      m4ci_pkg::SD_T1:  t_r[1] <= m4ci_pkg::T_W'(acc_r);
      m4ci_pkg::SD_T2:  t_r[2] <= m4ci_pkg::T_W'(acc_r);
      m4ci_pkg::SD_COF: cof_r[cmd.cof_idx] <= cmd.cof_neg ? m4ci_pkg::COF_W'(-acc_r)
                                                          : m4ci_pkg::COF_W'(acc_r);
      m4ci_pkg::SD_DET: det_r <= acc_r;
      default: begin end
    endcase
  end

  // |D| * 2^32 < min_det * 2^(4F), compared exactly
  assign adet     = det_r[m4ci_pkg::ACC_W-1] ? m4ci_pkg::ACC_W'(-det_r) : det_r;
  assign lhs      = m4ci_pkg::CMP_W'(adet) << m4ci_pkg::MDET_FRAC;
  assign rhs      = m4ci_pkg::CMP_W'(md_r) << (4 * m4ci_pkg::FRAC_BITS);
  assign sing_nxt = (det_r == '0) || (lhs < rhs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sing_r <= 1'b0;
      md_r   <= '0;
    end else begin
      if (cmd.chk) begin
        sing_r <= sing_nxt;
      end
      if (cfg_we) begin
        md_r <= cfg_min_det;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      adet_r <= adet;
    end
  end

  // restoring division: (2|C| 2^(2F) + |D|) / (2|D|), one quotient bit per cycle
  assign acv = cof_rd[m4ci_pkg::COF_W-1] ? m4ci_pkg::COF_W'(-cof_rd) : cof_rd;
  assign ge  = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r  <= (m4ci_pkg::DIV_W'(acv) << (2 * m4ci_pkg::FRAC_BITS + 1))
                + m4ci_pkg::DIV_W'(adet_r);
      dsh_r  <= m4ci_pkg::DIV_W'(adet_r) << (E + 2);
      q_r    <= '0;
      rneg_r <= cof_rd[m4ci_pkg::COF_W-1] ^ det_r[m4ci_pkg::ACC_W-1];
    end else if (cmd.div_step) begin
      rem_r <= ge ? (rem_r - dsh_r) : rem_r;
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[m4ci_pkg::Q_W-2:0], ge};
    end
  end

  assign qv   = q_r[m4ci_pkg::Q_W-2:0];
  assign ovf  = q_r[m4ci_pkg::Q_W-1];
  assign qneg = -qv;

  always_comb begin
    if (rneg_r) begin
      res = (ovf || (qv > HALF)) ? MINV : qneg[E-1:0];
    end else begin
      res = (ovf || (qv >= HALF)) ? MAXV : qv[E-1:0];
    end
  end

  assign res_elem = sing_r ? '0 : res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_elem_r <= res_elem;
      out_sing_r <= sing_r;
      out_last_r <= cmd.last;
    end
  end

  assign stat.sing     = sing_r;
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_elem  = out_elem_r;
  assign out_sing  = out_sing_r;
  assign out_last  = out_last_r;

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sing_r) |-> (out_elem_r == '0))
    else $error("singular item with nonzero element");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while held");

endmodule

@@ src/matrix4x4_cofactor_inverse_unit.sv @@
// Top level of the 4x4 adjugate matrix inverse unit.
`timescale 1ns / 1ps

// Takes sixteen signed Q16.16 elements row by row, then returns sixteen inverse
// elements row by row, saturated to Q16.16, with the last one marked. If |det| is
// below min_det (unsigned Q31.32) or det is zero, sixteen zeros come out with singular set.
// Sequence per matrix: the load, then 16 minors x 9 products and 4 products for
// the determinant (one shared 8-bit-digit multiply-accumulate), a threshold test,
// then, per result, the one-bit-per-cycle restoring divider and hand-off (no
// division steps when singular). Input stalls from the sixteenth element until
// the last result is in the output register.
module matrix4x4_cofactor_inverse_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [m4ci_pkg::ELEM_W-1:0]  in_element_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [m4ci_pkg::ELEM_W-1:0]  out_element_out,
  output logic                                out_singular,
  output logic                                out_last_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [m4ci_pkg::MDET_W-1:0]         cfg_min_det
);

  m4ci_pkg::cmd_t  cmd;
  m4ci_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  m4ci_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  m4ci_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_elem     (in_element_in),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_min_det (cfg_min_det),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_elem    (out_element_out),
    .out_sing    (out_singular),
    .out_last    (out_last_out)
  );

endmodule
